FILE: design/tspcr_pkg.sv
package tspcr_pkg;

   localparam int NUM_STAGES = 9;
   localparam int CALC_STAGES = NUM_STAGES - 1;
   localparam int TIME_W = 63;
   localparam int PCR_W = 48;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [PCR_W-1:0] pcr_type;
   typedef logic [CALC_STAGES-1:0] calc_adv_type;

endpackage

FILE: design/ts_pcr_restamper_unit.sv
// Transport stream PCR restamper. Packet bytes enter one per beat on the req_ channel and
// leave in the same order on the rsp_ channel, one result beat per input beat. A beat
// reaches rsp_valid through the stage registers stage_ff[0] to stage_ff[8]. One beat per clock
// is sustained while rsp_ready stays high: the nine-stage pipeline carries every byte
// together with the PCR arithmetic for its packet, which scales the elapsed time by 27,
// then divides by 1000 and by 300 in overlapped long-division steps of 16-bit digits,
// each division taking one step per stage. A set packet_start restarts the byte count
// at the first byte of a packet; without it the count wraps after 188 bytes. The first
// PCR packet after reset defines time zero and passes unchanged; later PCR packets leave
// with bytes 6 to 11 replaced and rsp_restamped set on those bytes, unless the packet
// time lies before time zero. No clearing pass follows reset.
module ts_pcr_restamper_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_packet_start,
   input  tspcr_pkg::time_type req_now_ns,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_restamped,
   output logic                rsp_packet_end
);
   import tspcr_pkg::*;

   localparam int PACKET_BYTES = 188;
   localparam int POS_W = $clog2(PACKET_BYTES);
   localparam int PCR_LEN = 6;
   localparam int SLOT_W = $clog2(PCR_LEN);

   localparam logic [POS_W-1:0] POS_SYNC = POS_W'(0);
   localparam logic [POS_W-1:0] POS_ADAPT = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ADAPT_LEN = POS_W'(4);
   localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(5);
   localparam logic [POS_W-1:0] POS_PCR_FIRST = POS_W'(6);
   localparam logic [POS_W-1:0] POS_PCR_LAST = POS_W'(11);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

   localparam logic [7:0] SYNC_BYTE = 8'h47;
   localparam logic [7:0] ADAPT_FLAG = 8'h20;
   localparam logic [7:0] PCR_FLAG = 8'h10;
   localparam logic [7:0] MIN_ADAPT_LEN = 8'd7;

   typedef struct packed {
      logic [7:0]        data;
      logic              stamp;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } stage_type;

   logic [POS_W-1:0]      pos_ff, pos_in, pos;
   logic                  match_ff, match_in;
   logic                  first_seen_ff, first_seen_in;
   time_type              start_time_ff, start_time_in;
   time_type              packet_time_ff, packet_time_in;
   logic                  stamp, last;

   logic [NUM_STAGES-1:0] valid_ff;
   stage_type             stage_ff [NUM_STAGES];
   stage_type             head, tail;
   logic [NUM_STAGES-1:0] go;
   logic                  accept;

   pcr_type               pcr_bits;
   logic [PCR_LEN-1:0][7:0] pcr_bytes;

   assign accept = req_valid && go[0];

   always_comb begin
      pos = req_packet_start ? POS_SYNC : pos_ff;
      match_in = match_ff;
      first_seen_in = first_seen_ff;
      start_time_in = start_time_ff;
      packet_time_in = packet_time_ff;
      stamp = 1'b0;
      last = (pos == POS_LAST);
      case (pos)
         POS_SYNC: begin
            packet_time_in = req_now_ns;
            match_in = (req_in_byte == SYNC_BYTE);
         end
         POS_ADAPT: begin
            match_in = match_ff && ((req_in_byte & ADAPT_FLAG) != 8'h00);
         end
         POS_ADAPT_LEN: begin
            match_in = match_ff && (req_in_byte >= MIN_ADAPT_LEN);
         end
         POS_FLAGS: begin
            match_in = 1'b0;
            if (match_ff && ((req_in_byte & PCR_FLAG) != 8'h00)) begin
               if (!first_seen_ff) begin
                  first_seen_in = 1'b1;
                  start_time_in = packet_time_ff;
               end else if (packet_time_ff >= start_time_ff) begin
                  match_in = 1'b1;
               end
            end
         end
         default: begin
            stamp = match_ff && (pos inside {[POS_PCR_FIRST:POS_PCR_LAST]});
         end
      endcase
      pos_in = last ? POS_SYNC : pos + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_SYNC;
         match_ff <= 1'b0;
         first_seen_ff <= 1'b0;
         start_time_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         match_ff <= match_in;
         first_seen_ff <= first_seen_in;
         start_time_ff <= start_time_in;
      end
      if (accept) begin
         packet_time_ff <= packet_time_in;
      end
   end

   always_comb begin
      go[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         go[i] = !valid_ff[i] || go[i+1];
      end
   end

   tspcr_calc u_calc (
      .clock       (clock),
      .adv         (go[CALC_STAGES-1:0]),
      .packet_time (packet_time_ff),
      .start_time  (start_time_ff),
      .pcr_bits    (pcr_bits)
   );

   assign pcr_bytes = pcr_bits;

   always_comb begin
      head.data = req_in_byte;
      head.stamp = stamp;
      head.slot = SLOT_W'(POS_PCR_LAST - pos);
      head.last = last;
      tail = stage_ff[NUM_STAGES-2];
      if (tail.stamp) begin
         tail.data = pcr_bytes[tail.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (go[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         stage_ff[0] <= head;
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (go[i]) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
      if (go[NUM_STAGES-1]) begin
         stage_ff[NUM_STAGES-1] <= tail;
      end
   end

   assign req_ready = go[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_out_byte = stage_ff[NUM_STAGES-1].data;
   assign rsp_restamped = stage_ff[NUM_STAGES-1].stamp;
   assign rsp_packet_end = stage_ff[NUM_STAGES-1].last;

   a_first_sticky: assert property (@(posedge clock) disable iff (reset)
      first_seen_ff |=> first_seen_ff)
      else $error("First PCR flag dropped without reset.");

   a_start_once: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(start_time_ff)) |-> $rose(first_seen_ff))
      else $error("Start time changed outside the first PCR packet.");

   a_stamp_after_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restamped) |-> first_seen_ff)
      else $error("Restamped beat before any PCR packet was seen.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && !rsp_ready))
      else $error("Input stalled while the pipeline had room.");

endmodule

FILE: design/tspcr_calc.sv
module tspcr_calc (
   input  logic                    clock,
   input  tspcr_pkg::calc_adv_type adv,
   input  tspcr_pkg::time_type     packet_time,
   input  tspcr_pkg::time_type     start_time,
   output tspcr_pkg::pcr_type      pcr_bits
);
   import tspcr_pkg::*;

   localparam int WIDE_W = 64;
   localparam int DIGIT_W = 16;

   localparam int REM_A_W = 7;
   localparam int NUM_A_W = REM_A_W + DIGIT_W;
   localparam int PROD_A_W = NUM_A_W + 24;
   localparam int SHIFT_A = 30;
   localparam int RECIP_A = 8589935;
   localparam int DIV_A = 125;

   localparam int REM_B_W = 9;
   localparam int NUM_B_W = REM_B_W + DIGIT_W;
   localparam int PROD_B_W = NUM_B_W + 26;
   localparam int SHIFT_B = 34;
   localparam int RECIP_B = 57266231;
   localparam int DIV_B = 300;

   localparam int BASE_W = 33;
   localparam logic [7:0] RESERVED_ONES = 8'h7e;

   // One long-division digit step by 125, exact through a reciprocal multiply.
   function automatic logic [DIGIT_W+REM_A_W-1:0] step_a(input logic [REM_A_W-1:0] rem,
                                                         input logic [DIGIT_W-1:0] dig);
      logic [NUM_A_W-1:0]  num;
      logic [PROD_A_W-1:0] prod;
      logic [DIGIT_W-1:0]  quo;
      logic [REM_A_W-1:0]  back;
      num = {rem, dig};
      prod = PROD_A_W'(num) * PROD_A_W'(RECIP_A);
      quo = prod[SHIFT_A +: DIGIT_W];
      back = REM_A_W'(quo) * REM_A_W'(DIV_A);
      return {quo, num[REM_A_W-1:0] - back};
   endfunction

   // One long-division digit step by 300.
   function automatic logic [DIGIT_W+REM_B_W-1:0] step_b(input logic [REM_B_W-1:0] rem,
                                                         input logic [DIGIT_W-1:0] dig);
      logic [NUM_B_W-1:0]  num;
      logic [PROD_B_W-1:0] prod;
      logic [DIGIT_W-1:0]  quo;
      logic [REM_B_W-1:0]  back;
      num = {rem, dig};
      prod = PROD_B_W'(num) * PROD_B_W'(RECIP_B);
      quo = prod[SHIFT_B +: DIGIT_W];
      back = REM_B_W'(quo) * REM_B_W'(DIV_B);
      return {quo, num[REM_B_W-1:0] - back};
   endfunction

   logic [TIME_W-1:0]          elapsed_ff;
   logic [WIDE_W-1:0]          triple_ff;
   logic [WIDE_W-1:0]          scaled_ff;
   logic [DIGIT_W-1:0]         ta3_ff, ta4_ff, ta5_ff, ta6_ff;
   logic [REM_A_W-1:0]         ra3_ff, ra4_ff, ra5_ff;
   logic [3*DIGIT_W-1:0]       qlo3_ff;
   logic [2*DIGIT_W-1:0]       qlo4_ff;
   logic [DIGIT_W-1:0]         qlo5_ff;
   logic [REM_B_W-1:0]         rb4_ff, rb5_ff, rb6_ff;
   logic                       bb5_ff;
   logic [DIGIT_W:0]           bhi6_ff;
   logic [BASE_W-1:0]          base7_ff;
   logic [REM_B_W-1:0]         ext7_ff;

   logic [DIGIT_W+REM_A_W-1:0] sa3, sa4, sa5, sa6;
   logic [DIGIT_W+REM_B_W-1:0] sb4, sb5, sb6, sb7;

   always_comb begin
      sa3 = step_a('0, DIGIT_W'(scaled_ff[WIDE_W-1:3*DIGIT_W+3]));
      sa4 = step_a(ra3_ff, qlo3_ff[3*DIGIT_W-1:2*DIGIT_W]);
      sa5 = step_a(ra4_ff, qlo4_ff[2*DIGIT_W-1:DIGIT_W]);
      sa6 = step_a(ra5_ff, qlo5_ff);
      sb4 = step_b('0, ta3_ff);
      sb5 = step_b(rb4_ff, ta4_ff);
      sb6 = step_b(rb5_ff, ta5_ff);
      sb7 = step_b(rb6_ff, ta6_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         elapsed_ff <= packet_time - start_time;
      end
      if (adv[1]) begin
         triple_ff <= {1'b0, elapsed_ff} + {elapsed_ff, 1'b0};
      end
      if (adv[2]) begin
         scaled_ff <= triple_ff + {triple_ff[WIDE_W-4:0], 3'b000};
      end
      if (adv[3]) begin
         ta3_ff <= sa3[REM_A_W +: DIGIT_W];
         ra3_ff <= sa3[REM_A_W-1:0];
         qlo3_ff <= scaled_ff[3*DIGIT_W+2:3];
      end
      if (adv[4]) begin
         ta4_ff <= sa4[REM_A_W +: DIGIT_W];
         ra4_ff <= sa4[REM_A_W-1:0];
         qlo4_ff <= qlo3_ff[2*DIGIT_W-1:0];
         rb4_ff <= sb4[REM_B_W-1:0];
      end
      if (adv[5]) begin
         ta5_ff <= sa5[REM_A_W +: DIGIT_W];
         ra5_ff <= sa5[REM_A_W-1:0];
         qlo5_ff <= qlo4_ff[DIGIT_W-1:0];
         rb5_ff <= sb5[REM_B_W-1:0];
         bb5_ff <= sb5[REM_B_W];
      end
      if (adv[6]) begin
         ta6_ff <= sa6[REM_A_W +: DIGIT_W];
         rb6_ff <= sb6[REM_B_W-1:0];
         bhi6_ff <= {bb5_ff, sb6[REM_B_W +: DIGIT_W]};
      end
      if (adv[7]) begin
         base7_ff <= {bhi6_ff, sb7[REM_B_W +: DIGIT_W]};
         ext7_ff <= sb7[REM_B_W-1:0];
      end
   end

   assign pcr_bits = {base7_ff[32:25], base7_ff[24:17], base7_ff[16:9], base7_ff[8:1],
                      ({base7_ff[0], 7'b0000000} | {7'b0000000, ext7_ff[8]} | RESERVED_ONES),
                      ext7_ff[7:0]};

endmodule
